>>> rtl/core/dpswd_pkg.sv
// ----------------------------------------------------------------------------
// dpswd_pkg
// Shared constants for the dual-phase sync word deframer: field widths,
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package dpswd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int BYTE_W     = 8;
	localparam int SYNC_W     = 16;
	localparam int LEN_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Bits collected in one packet: packet length in bytes times eight.
	localparam int BYTE_SHIFT = 3;
	localparam int COUNT_W    = LEN_W + BYTE_SHIFT;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [BYTE_W-1:0]          byte_t;
	typedef logic [SYNC_W-1:0]          sync_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

	// Configuration register indexes
	localparam cfg_idx_t CFG_PACKET_BYTES = 2'd0;
	localparam cfg_idx_t CFG_SYNC_WORD    = 2'd1;

	// Reset values
	localparam len_t  PACKET_BYTES_RST = 16'd70;
	localparam sync_t SYNC_WORD_RST    = 16'h2dd4;

endpackage

>>> rtl/core/dpswd_sample_if.sv
// ----------------------------------------------------------------------------
// dpswd_sample_if
// Input channel: one bit pair per beat, two complex samples.
// ----------------------------------------------------------------------------
interface dpswd_sample_if;

	logic               valid;
	logic               ready;
	dpswd_pkg::sample_t first_real;
	dpswd_pkg::sample_t first_imag;
	dpswd_pkg::sample_t second_real;
	dpswd_pkg::sample_t second_imag;

	modport source (
		output valid, first_real, first_imag, second_real, second_imag,
		input  ready
	);

	modport sink (
		input  valid, first_real, first_imag, second_real, second_imag,
		output ready
	);

endinterface

>>> rtl/core/dpswd_byte_if.sv
// ----------------------------------------------------------------------------
// dpswd_byte_if
// Output channel: one deframed payload byte per beat.
// ----------------------------------------------------------------------------
interface dpswd_byte_if;

	logic             valid;
	logic             ready;
	dpswd_pkg::byte_t data_byte;
	logic             last_byte;
	logic             locked_phase;

	modport source (
		output valid, data_byte, last_byte, locked_phase,
		input  ready
	);

	modport sink (
		input  valid, data_byte, last_byte, locked_phase,
		output ready
	);

endinterface

>>> rtl/core/dpswd_cfg_if.sv
// ----------------------------------------------------------------------------
// dpswd_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface dpswd_cfg_if;

	logic                 valid;
	logic                 ready;
	dpswd_pkg::cfg_idx_t  index;
	dpswd_pkg::cfg_data_t data;

	modport source (
		output valid, index, data,
		input  ready
	);

	modport sink (
		input  valid, index, data,
		output ready
	);

endinterface

>>> rtl/core/dual_phase_sync_word_deframer.sv
// ----------------------------------------------------------------------------
// dual_phase_sync_word_deframer
// Hard-decides two sample phases per bit, hunts for the sync word in both
// phases, then assembles bytes from the locked phase for one packet.
// ----------------------------------------------------------------------------
//
//  channel   modport  beat carries
//  -------   -------  -------------------------------------------------------
//  samples   sink     first_real, first_imag, second_real, second_imag
//  payload   source   data_byte, last_byte, locked_phase
//  cfg       sink     index, data (0: packet_bytes, 1: sync_word)
//
//  One bit pair per cycle sustained unless stalled. A sample beat is registered
//  after its hard decision, then passes on to the output register, so a byte
//  leaves through the input register and the output register in that order.
//  The input stalls only while the output register holds an untaken byte
//  and a bit pair is already waiting in the input register.
//  Reset returns to hunting with cleared hunt registers and default config.
//  cfg is always ready.
//
module dual_phase_sync_word_deframer (
	input  logic                  clk,
	input  logic                  arst_n,
	dpswd_sample_if.sink          samples,
	dpswd_byte_if.source          payload,
	dpswd_cfg_if.sink             cfg
);

	localparam logic [1:0] LOCK_HUNT   = 2'd0;
	localparam logic [1:0] LOCK_FIRST  = 2'd1;
	localparam logic [1:0] LOCK_SECOND = 2'd2;

	// configuration
	dpswd_pkg::len_t   packet_bytes_q;
	dpswd_pkg::sync_t  sync_word_q;

	// input register: decided bits
	logic              valid_s1;
	logic              bit_a_s1;
	logic              bit_b_s1;

	// deframer state
	dpswd_pkg::sync_t  hunt_a_q;
	dpswd_pkg::sync_t  hunt_b_q;
	logic [1:0]        lock_q;
	dpswd_pkg::count_t bit_cnt_q;
	dpswd_pkg::byte_t  byte_q;

	// output register
	logic              out_valid_s2;
	dpswd_pkg::byte_t  data_s2;
	logic              last_s2;
	logic              phase_s2;

	logic              advance;
	logic              locked;
	logic              bit_sel;
	dpswd_pkg::byte_t  byte_nxt;
	dpswd_pkg::count_t cnt_inc;
	dpswd_pkg::count_t total_bits;
	logic              done;
	logic              emit;
	logic              hunting;
	dpswd_pkg::sync_t  hunt_a_nxt;
	dpswd_pkg::sync_t  hunt_b_nxt;

	assign cfg.ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_s2 || payload.ready);
	assign samples.ready = !valid_s1 || advance;

	assign locked     = (lock_q == LOCK_FIRST) || (lock_q == LOCK_SECOND);
	assign bit_sel    = (lock_q == LOCK_SECOND) ? bit_b_s1 : bit_a_s1;
	assign byte_nxt   = {byte_q[dpswd_pkg::BYTE_W-2:0], bit_sel};
	assign cnt_inc    = bit_cnt_q + dpswd_pkg::count_t'(1);
	assign total_bits = {packet_bytes_q, {dpswd_pkg::BYTE_SHIFT{1'b0}}};
	assign done       = locked && (cnt_inc >= total_bits);
	assign emit       = locked && (cnt_inc[dpswd_pkg::BYTE_SHIFT-1:0] == '0);
	// the packet's final bit also feeds the hunt registers
	assign hunting    = !locked || done;
	assign hunt_a_nxt = {hunt_a_q[dpswd_pkg::SYNC_W-2:0], bit_a_s1};
	assign hunt_b_nxt = {hunt_b_q[dpswd_pkg::SYNC_W-2:0], bit_b_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_bytes_q <= dpswd_pkg::PACKET_BYTES_RST;
			sync_word_q    <= dpswd_pkg::SYNC_WORD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dpswd_pkg::CFG_PACKET_BYTES: packet_bytes_q <= cfg.data;
				dpswd_pkg::CFG_SYNC_WORD:    sync_word_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// hard decision ahead of the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			bit_a_s1 <= samples.first_real > samples.first_imag;
			bit_b_s1 <= samples.second_real > samples.second_imag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_a_q  <= '0;
			hunt_b_q  <= '0;
			lock_q    <= LOCK_HUNT;
			bit_cnt_q <= '0;
			byte_q    <= '0;
		end else if (advance) begin
			if (locked) begin
				byte_q    <= byte_nxt;
				bit_cnt_q <= done ? '0 : cnt_inc;
			end
			if (hunting) begin
				hunt_a_q <= hunt_a_nxt;
				hunt_b_q <= hunt_b_nxt;
				if (hunt_a_nxt == sync_word_q) begin
					lock_q <= LOCK_FIRST;
				end else if (hunt_b_nxt == sync_word_q) begin
					lock_q <= LOCK_SECOND;
				end else begin
					lock_q <= LOCK_HUNT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= emit;
		end else if (payload.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			data_s2  <= byte_nxt;
			last_s2  <= done;
			phase_s2 <= (lock_q == LOCK_SECOND);
		end
	end

	assign payload.valid        = out_valid_s2;
	assign payload.data_byte    = data_s2;
	assign payload.last_byte    = last_s2;
	assign payload.locked_phase = phase_s2;

endmodule

>>> rtl/core/dpswd_checker.sv
// ----------------------------------------------------------------------------
// dpswd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module dpswd_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             out_valid,
	input  logic             out_ready,
	input  dpswd_pkg::byte_t out_data,
	input  logic             out_last,
	input  logic             out_phase,
	input  logic             cfg_valid,
	input  logic             cfg_ready
);

	// a stalled output beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)
			&& $stable(out_last) && $stable(out_phase))
		else $error("output beat changed while stalled");

	// input backpressure comes only from a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a new byte must trace back to an accepted sample beat
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output byte without matching input beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind dual_phase_sync_word_deframer dpswd_checker u_dpswd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (payload.valid),
	.out_ready (payload.ready),
	.out_data  (payload.data_byte),
	.out_last  (payload.last_byte),
	.out_phase (payload.locked_phase),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

>>> verif/dpswd_byte_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dpswd_byte_checker
// Watches the sample, payload and config channels of the deframer, tracks
// hunt, lock and byte assembly for every accepted bit pair and compares each
// payload beat with the oldest byte still owed.
// ----------------------------------------------------------------------------
module dpswd_byte_checker (
	input  logic    clk,
	input  logic    arst_n,
	dpswd_sample_if samples,
	dpswd_byte_if   payload,
	dpswd_cfg_if    cfg,
	output int      errors,
	output int      pending
);

	typedef enum logic [1:0] {
		HUNTING     = 2'd0,
		LOCK_FIRST  = 2'd1,
		LOCK_SECOND = 2'd2
	} lock_e;

	typedef struct packed {
		dpswd_pkg::byte_t data_byte;
		logic             last_byte;
		logic             locked_phase;
	} frame_byte_t;

	dpswd_pkg::len_t   pkt_len;
	dpswd_pkg::sync_t  sync_pat;
	dpswd_pkg::sync_t  hunt_first;
	dpswd_pkg::sync_t  hunt_second;
	lock_e             mode;
	dpswd_pkg::count_t bit_cnt;
	dpswd_pkg::byte_t  assembly;
	frame_byte_t       owed_bytes[$];
	frame_byte_t       oldest;

	function automatic logic hard_bit(dpswd_pkg::sample_t re, dpswd_pkg::sample_t im);
		return re > im;
	endfunction

	function automatic void take_bit_pair(logic bit_a, logic bit_b);
		dpswd_pkg::count_t total;
		logic              taken;
		logic              done;
		total = {pkt_len, {dpswd_pkg::BYTE_SHIFT{1'b0}}};
		if (mode != HUNTING) begin
			taken = (mode == LOCK_FIRST) ? bit_a : bit_b;
			assembly = {assembly[dpswd_pkg::BYTE_W-2:0], taken};
			bit_cnt = bit_cnt + 1'b1;
			done = (bit_cnt >= total);
			if (bit_cnt[dpswd_pkg::BYTE_SHIFT-1:0] == '0)
				owed_bytes.push_back('{data_byte: assembly, last_byte: done,
					locked_phase: (mode == LOCK_SECOND)});
			if (done) begin
				mode = HUNTING;
				bit_cnt = '0;
			end
		end
		// the packet-end bit also shifts into the hunt registers
		if (mode == HUNTING) begin
			hunt_first = {hunt_first[dpswd_pkg::SYNC_W-2:0], bit_a};
			hunt_second = {hunt_second[dpswd_pkg::SYNC_W-2:0], bit_b};
			if (hunt_first == sync_pat)
				mode = LOCK_FIRST;
			else if (hunt_second == sync_pat)
				mode = LOCK_SECOND;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_len = dpswd_pkg::PACKET_BYTES_RST;
			sync_pat = dpswd_pkg::SYNC_WORD_RST;
			hunt_first = '0;
			hunt_second = '0;
			mode = HUNTING;
			bit_cnt = '0;
			assembly = '0;
			owed_bytes.delete();
			errors = 0;
		end else begin
			if (payload.valid && payload.ready) begin
				if (owed_bytes.size() == 0) begin
					$error("payload beat %02h arrived with no byte owed", payload.data_byte);
					errors++;
				end else begin
					oldest = owed_bytes.pop_front();
					if (payload.data_byte !== oldest.data_byte) begin
						$error("data_byte: expected %02h, got %02h",
							oldest.data_byte, payload.data_byte);
						errors++;
					end
					if (payload.last_byte !== oldest.last_byte) begin
						$error("last_byte: expected %0d, got %0d",
							oldest.last_byte, payload.last_byte);
						errors++;
					end
					if (payload.locked_phase !== oldest.locked_phase) begin
						$error("locked_phase: expected %0d, got %0d",
							oldest.locked_phase, payload.locked_phase);
						errors++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					dpswd_pkg::CFG_PACKET_BYTES: pkt_len = cfg.data;
					dpswd_pkg::CFG_SYNC_WORD:    sync_pat = cfg.data;
					default: ;
				endcase
			end
			if (samples.valid && samples.ready)
				take_bit_pair(hard_bit(samples.first_real, samples.first_imag),
					hard_bit(samples.second_real, samples.second_imag));
		end
		pending = owed_bytes.size();
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives bit pairs into the deframer as short packets (noise, sync word in
// one or both phases, payload) under several packet lengths and sync words,
// with bursty input and a stalling payload sink; the checker does the rest.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int PAIR_TARGET  = 950;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_PAYLOAD = 48;

	typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_pattern_e;
	typedef enum int {LANE_FIRST, LANE_SECOND, LANE_BOTH} lane_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   pairs_sent;
	int   burst_left;

	dpswd_sample_if samples ();
	dpswd_byte_if   payload ();
	dpswd_cfg_if    cfg ();

	dual_phase_sync_word_deframer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.payload (payload),
		.cfg     (cfg)
	);

	dpswd_byte_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.payload (payload),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// payload sink: switch now and then between stall patterns
	initial begin
		rx_pattern_e rx_mode;
		int          left;
		rx_mode = RX_FREE;
		left = 0;
		payload.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				rx_mode = rx_pattern_e'($urandom_range(RX_FREE, RX_BURSTY));
				left = $urandom_range(20, 80);
			end
			left--;
			case (rx_mode)
				RX_FREE:   payload.ready <= 1'b1;
				RX_RANDOM: payload.ready <= ($urandom_range(0, 9) < 7);
				RX_SPARSE: payload.ready <= (left % 4 == 0);
				default:   payload.ready <= (left % 16 >= 10);
			endcase
		end
	end

	function automatic dpswd_pkg::sample_t pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return '0;
			3:       return '1;
			default: return dpswd_pkg::sample_t'($urandom);
		endcase
	endfunction

	// real/imag pair that hard-decides to the wanted bit
	task automatic pick_pair(input logic want, output dpswd_pkg::sample_t re,
			output dpswd_pkg::sample_t im);
		dpswd_pkg::sample_t a;
		dpswd_pkg::sample_t b;
		a = pick_value();
		b = pick_value();
		if (!want && $urandom_range(0, 7) == 0)
			b = a;
		if ((a > b) != want) begin
			re = b;
			im = a;
		end else begin
			re = a;
			im = b;
		end
		// equal parts decide to zero: nudge apart
		if (want && re == im) begin
			if (re == 16'sh8000)
				re = re + 16'sd1;
			else
				im = im - 16'sd1;
		end
	endtask

	task automatic drive_beat(input dpswd_pkg::sample_t fr, input dpswd_pkg::sample_t fi,
			input dpswd_pkg::sample_t sr, input dpswd_pkg::sample_t si);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk);
				samples.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		samples.valid <= 1'b1;
		samples.first_real <= fr;
		samples.first_imag <= fi;
		samples.second_real <= sr;
		samples.second_imag <= si;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		burst_left--;
		pairs_sent++;
	endtask

	task automatic send_pair(input logic bit_a, input logic bit_b);
		dpswd_pkg::sample_t fr;
		dpswd_pkg::sample_t fi;
		dpswd_pkg::sample_t sr;
		dpswd_pkg::sample_t si;
		pick_pair(bit_a, fr, fi);
		pick_pair(bit_b, sr, si);
		drive_beat(fr, fi, sr, si);
	endtask

	// drop valid and hold until every owed byte is out and the pipe is empty
	task automatic settle();
		@(negedge clk);
		samples.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input dpswd_pkg::cfg_idx_t idx,
			input dpswd_pkg::cfg_data_t value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic send_packet(input dpswd_pkg::sync_t pattern, input int payload_bits);
		lane_e lane;
		int    flip;
		logic  s;
		repeat ($urandom_range(0, 12)) send_pair(1'($urandom), 1'($urandom));
		lane = lane_e'($urandom_range(LANE_FIRST, LANE_BOTH));
		// now and then corrupt one sync bit
		flip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, dpswd_pkg::SYNC_W - 1) : -1;
		for (int i = dpswd_pkg::SYNC_W - 1; i >= 0; i--) begin
			s = pattern[i] ^ (i == flip);
			send_pair((lane != LANE_SECOND) ? s : 1'($urandom),
				(lane != LANE_FIRST) ? s : 1'($urandom));
		end
		repeat (payload_bits) send_pair(1'($urandom), 1'($urandom));
	endtask

	task automatic run_phase(input dpswd_pkg::len_t len, input dpswd_pkg::sync_t pattern,
			input int packets);
		int bits;
		settle();
		write_reg(dpswd_pkg::CFG_PACKET_BYTES, len);
		write_reg(dpswd_pkg::CFG_SYNC_WORD, pattern);
		@(negedge clk);
		cfg.valid <= 1'b0;
		if (len == 0)
			bits = 1;
		else if (len > 6)
			bits = LONG_PAYLOAD;
		else
			bits = len * 8;
		repeat (packets) send_packet(pattern, bits);
	endtask

	initial begin
		samples.valid = 1'b0;
		samples.first_real = '0;
		samples.first_imag = '0;
		samples.second_real = '0;
		samples.second_imag = '0;
		cfg.valid = 1'b0;
		cfg.index = dpswd_pkg::CFG_PACKET_BYTES;
		cfg.data = '0;
		burst_left = 0;
		pairs_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// field extremes and equal parts
		drive_beat(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		drive_beat(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		drive_beat(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
		drive_beat(16'sh0000, 16'shffff, 16'shffff, 16'sh0000);
		drive_beat(16'shffff, 16'sh0000, 16'sh0000, 16'shffff);
		drive_beat(16'sh7fff, 16'sh7ffe, 16'sh8001, 16'sh8000);
		// default sync word in both phases at once: first phase wins
		for (int i = dpswd_pkg::SYNC_W - 1; i >= 0; i--)
			send_pair(dpswd_pkg::SYNC_WORD_RST[i], dpswd_pkg::SYNC_WORD_RST[i]);

		// shorten the packet while locked, then walk through the settings
		run_phase(16'd1, dpswd_pkg::SYNC_WORD_RST, 4);
		run_phase(16'd0, 16'ha5c3, 6);
		run_phase(16'd1, 16'h0000, 5);
		run_phase(16'd2, 16'hffff, 5);
		run_phase(16'hffff, dpswd_pkg::sync_t'($urandom), 1);
		// cut the long packet short: it ends on the next collected bit
		run_phase(16'd2, dpswd_pkg::sync_t'($urandom), 4);
		while (pairs_sent < PAIR_TARGET)
			run_phase(dpswd_pkg::len_t'($urandom_range(1, 5)),
				dpswd_pkg::sync_t'($urandom), $urandom_range(2, 6));
		settle();

		if (errors == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
